// ----- design/pslf_pkg.sv -----
// ----------------------------------------------------------------------------
// pslf_pkg - shared types and constants of the speed loop
// Field widths, register map, feedforward modes and the request and response
// bundles of the bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
package pslf_pkg;

   // parameter defaults
   localparam int GAIN_FRAC_BITS_DEF = 24;
   localparam int INTEGRAL_WIDTH_DEF = 48;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // field widths
   localparam int GAIN_W   = 32;
   localparam int TARGET_W = 15;
   localparam int SPEED_W  = 16;
   localparam int DT_W     = 16;
   localparam int DUTY_W   = 8;
   localparam int ERR_W    = 17;
   localparam int PERR_W   = 18;
   localparam int FFDIV_W  = 24;
   localparam int FFDIV_FRAC = 8;
   localparam int MODE_W   = 2;

   // serial arithmetic
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = 61;
   localparam int MSUM_W  = 65;
   localparam int STEP_W  = 6;
   localparam int SUM_W   = 56;
   localparam int TERM_LOG = 50;
   localparam int K_W     = 10;

   localparam logic [PROD_W-1:0] PROD_CAP = PROD_W'(1) << (PROD_W - 1);
   localparam logic [PROD_W-1:0] TERM_MAX = PROD_W'(1) << TERM_LOG;
   localparam logic [K_W-1:0]    K_THOUSAND = 10'd1000;

   // register map
   typedef logic [2:0] reg_idx_type;
   localparam reg_idx_type REG_GAIN_P     = 3'd0;
   localparam reg_idx_type REG_GAIN_I     = 3'd1;
   localparam reg_idx_type REG_GAIN_D     = 3'd2;
   localparam reg_idx_type REG_TARGET     = 3'd3;
   localparam reg_idx_type REG_FF_MODE    = 3'd4;
   localparam reg_idx_type REG_FF_FIXED   = 3'd5;
   localparam reg_idx_type REG_FF_DIVISOR = 3'd6;
   localparam reg_idx_type REG_ENABLE     = 3'd7;

   // feedforward modes (the fourth code adds nothing)
   localparam logic [MODE_W-1:0] FF_NONE  = 2'd0;
   localparam logic [MODE_W-1:0] FF_FIXED = 2'd1;
   localparam logic [MODE_W-1:0] FF_PROP  = 2'd2;

   // reset values
   localparam logic [TARGET_W-1:0] TARGET_RST  = 15'd19200;
   localparam logic [DUTY_W-1:0]   DUTY_RST    = 8'd190;
   localparam logic [FFDIV_W-1:0]  FFDIV_RST   = 24'd25600;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_i;
      logic [GAIN_W-1:0]   gain_d;
      logic [TARGET_W-1:0] speed_target;
      logic [MODE_W-1:0]   ff_mode;
      logic [DUTY_W-1:0]   ff_fixed;
      logic [FFDIV_W-1:0]  ff_divisor;
      logic                motor_enable;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
      logic [STEP_W-1:0]  steps;
   } mul_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic               start;
      logic [PROD_W-1:0]  num;
      logic [FFDIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] quo;
   } div_rsp_type;

endpackage

// ----- design/pslf_sermul.sv -----
// ----------------------------------------------------------------------------
// pslf_sermul - bit-serial saturating multiplier
// Walks the multiplier operand MSB first, one bit per cycle, doubling the
// partial product and adding the multiplicand. Saturates at PROD_CAP.
// ----------------------------------------------------------------------------
module pslf_sermul
   import pslf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [MSUM_W-1:0]  sum;
   logic               last;

   always_comb begin
      sum  = MSUM_W'({acc_ff, 1'b0})
           + (b_ff[MUL_B_W-1] ? MSUM_W'(a_ff) : MSUM_W'(0));
      last = busy_ff && (steps_ff == STEP_W'(1));
      a_in = a_ff;
      b_in = b_ff;
      steps_in = steps_ff;
      acc_in = acc_ff;
      busy_in = busy_ff;
      done_in = last;
      if (req.start) begin
         a_in = req.a;
         b_in = req.b;
         steps_in = req.steps;
         acc_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // clamp, the partial product only grows
         acc_in = (sum >= MSUM_W'(PROD_CAP)) ? PROD_CAP : sum[PROD_W-1:0];
         b_in = b_ff << 1;
         steps_in = steps_ff - STEP_W'(1);
         busy_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      steps_ff <= steps_in;
      acc_ff <= acc_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

// ----- design/pslf_serdiv.sv -----
// ----------------------------------------------------------------------------
// pslf_serdiv - bit-serial restoring divider
// One quotient bit per cycle, dividend shifted out MSB first while the
// quotient shifts in at the bottom of the same register.
// ----------------------------------------------------------------------------
module pslf_serdiv
   import pslf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [FFDIV_W-1:0] rem_ff, rem_in;
   logic [FFDIV_W-1:0] den_ff, den_in;
   logic [PROD_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [FFDIV_W:0]   trial;
   logic [FFDIV_W:0]   rest;
   logic               fits;
   logic               last;

   always_comb begin
      trial = {rem_ff, quo_ff[PROD_W-1]};
      rest  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
      last  = busy_ff && (steps_ff == STEP_W'(1));
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      steps_in = steps_ff;
      busy_in = busy_ff;
      done_in = last;
      if (req.start) begin
         rem_in = '0;
         den_in = req.den;
         quo_in = req.num;
         steps_in = STEP_W'(PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rest[FFDIV_W-1:0] : trial[FFDIV_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], fits};
         steps_in = steps_ff - STEP_W'(1);
         busy_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      steps_ff <= steps_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

// ----- design/pslf_csr.sv -----
// ----------------------------------------------------------------------------
// pslf_csr - configuration registers
// APB-style register file, one register per 32-bit word, always ready.
// ----------------------------------------------------------------------------
module pslf_csr
   import pslf_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   localparam longint unsigned ONE_F = 64'd1 << GAIN_FRAC_BITS;
   localparam logic [GAIN_W-1:0] GAIN_P_RST  = GAIN_W'((ONE_F + 10) / 20);
   localparam logic [GAIN_W-1:0] GAIN_ID_RST = GAIN_W'((ONE_F + 5000) / 10000);

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr;

   assign idx = csr_paddr[CSR_ADDR_W-1:2];
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_GAIN_P:     cfg_in.gain_p = csr_pwdata;
            REG_GAIN_I:     cfg_in.gain_i = csr_pwdata;
            REG_GAIN_D:     cfg_in.gain_d = csr_pwdata;
            REG_TARGET:     cfg_in.speed_target = csr_pwdata[TARGET_W-1:0];
            REG_FF_MODE:    cfg_in.ff_mode = csr_pwdata[MODE_W-1:0];
            REG_FF_FIXED:   cfg_in.ff_fixed = csr_pwdata[DUTY_W-1:0];
            REG_FF_DIVISOR: cfg_in.ff_divisor = csr_pwdata[FFDIV_W-1:0];
            REG_ENABLE:     cfg_in.motor_enable = csr_pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_GAIN_P:     csr_prdata = cfg_ff.gain_p;
         REG_GAIN_I:     csr_prdata = cfg_ff.gain_i;
         REG_GAIN_D:     csr_prdata = cfg_ff.gain_d;
         REG_TARGET:     csr_prdata = CSR_DATA_W'(cfg_ff.speed_target);
         REG_FF_MODE:    csr_prdata = CSR_DATA_W'(cfg_ff.ff_mode);
         REG_FF_FIXED:   csr_prdata = CSR_DATA_W'(cfg_ff.ff_fixed);
         REG_FF_DIVISOR: csr_prdata = CSR_DATA_W'(cfg_ff.ff_divisor);
         REG_ENABLE:     csr_prdata = CSR_DATA_W'(cfg_ff.motor_enable);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p       <= GAIN_P_RST;
         cfg_ff.gain_i       <= GAIN_ID_RST;
         cfg_ff.gain_d       <= GAIN_ID_RST;
         cfg_ff.speed_target <= TARGET_RST;
         cfg_ff.ff_mode      <= FF_PROP;
         cfg_ff.ff_fixed     <= DUTY_RST;
         cfg_ff.ff_divisor   <= FFDIV_RST;
         cfg_ff.motor_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

endmodule

// ----- design/pid_speed_loop_feedforward_unit.sv -----
// ----------------------------------------------------------------------------
// pid_speed_loop_feedforward_unit - PID speed loop with feedforward
// Turns speed measurements into an 8-bit PWM duty using a bit-serial
// multiplier and divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction per measurement, tdata = speed (bits 15:0)
//   and elapsed microseconds (bits 31:16). rsp channel: one transaction per
//   measurement, tdata = drive (7:0) and speed error (24:8), tuser = flag
//   that the PID update ran. The csr port holds gains, target, feedforward
//   mode and the enable; write it only while the loop is idle.
//   A repeated speed skips the serial units and goes straight to the output
//   state. A new speed runs five serial products (17, 17, 10, 32 and 16 bit
//   steps) and two or three 61-step divisions, the third only with
//   proportional feedforward, one unit busy at a time. A new measurement is
//   taken only once the previous one has left the sequencer.
//   Reset clears the integral, the previous error and speed, sets the held
//   duty to 190 and loads the register defaults.
//   A stalled receiver holds the finished result in the output register;
//   the next transaction is still taken and works until its own result
//   needs the register.
// ----------------------------------------------------------------------------
module pid_speed_loop_feedforward_unit
   import pslf_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
   parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // speed_meas[15:0], elapsed_us[31:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // drive[7:0], speed_error[24:8], zeros
   output logic                  rsp_tuser    // recomputed
);

   localparam int IW = INTEGRAL_WIDTH;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_MUL_P  = 12'b0000_0000_0010,
      ST_MUL_D1 = 12'b0000_0000_0100,
      ST_MUL_D2 = 12'b0000_0000_1000,
      ST_DIV_D  = 12'b0000_0001_0000,
      ST_MUL_I1 = 12'b0000_0010_0000,
      ST_MUL_I2 = 12'b0000_0100_0000,
      ST_DIV_I  = 12'b0000_1000_0000,
      ST_DIV_F  = 12'b0001_0000_0000,
      ST_SUM    = 12'b0010_0000_0000,
      ST_DUTY   = 12'b0100_0000_0000,
      ST_OUT    = 12'b1000_0000_0000
   } state_type;

   cfg_type     cfg;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type state_ff, state_in;
   logic      go_ff, go_in;

   // item registers
   logic [SPEED_W-1:0]       speed_ff, speed_in;
   logic [DT_W-1:0]          dt_ff, dt_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [PERR_W-1:0] diff_ff, diff_in;
   logic                     run_ff, run_in;
   logic signed [SUM_W-1:0]  total_ff, total_in;

   // loop state
   logic signed [IW-1:0]     integ_ff, integ_in;
   logic signed [PERR_W-1:0] perr_ff, perr_in;
   logic [SPEED_W-1:0]       pspeed_ff, pspeed_in;
   logic [DUTY_W-1:0]        held_ff, held_in;

   // output register
   logic                     rvalid_ff, rvalid_in;
   logic [DUTY_W-1:0]        rdrive_ff, rdrive_in;
   logic                     rrecomp_ff, rrecomp_in;
   logic signed [ERR_W-1:0]  rerr_ff, rerr_in;

   logic                     accept;
   logic                     out_free;
   logic [SPEED_W-1:0]       meas;
   logic [DT_W-1:0]          elapsed;
   logic signed [ERR_W-1:0]  err_now;
   logic signed [IW:0]       integ_sum;
   logic [ERR_W-1:0]         err_neg, err_mag;
   logic [PERR_W-1:0]        diff_neg;
   logic [ERR_W-1:0]         diff_mag;
   logic [IW-1:0]            integ_mag;
   logic [PROD_W-1:0]        quo_cap;
   logic [SUM_W-1:0]         term_mag;
   logic                     term_neg;
   logic                     term_add;
   logic signed [SUM_W-1:0]  term_val;
   logic [SUM_W-1:0]         tot_shift;
   logic                     tot_pos;

   pslf_csr #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pslf_sermul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   pslf_serdiv u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rvalid_ff || rsp_tready;

   // item decode and integral update
   always_comb begin
      meas      = req_tdata[SPEED_W-1:0];
      elapsed   = req_tdata[SPEED_W+DT_W-1:SPEED_W];
      err_now   = signed'({2'b00, cfg.speed_target}) - signed'({1'b0, meas});
      integ_sum = IW'(integ_ff) + (IW+1)'(err_now);
      integ_sum = {integ_ff[IW-1], integ_ff} + (IW+1)'(err_now);
      err_neg   = -err_ff;
      err_mag   = err_ff[ERR_W-1] ? err_neg : err_ff;
      diff_neg  = -diff_ff;
      diff_mag  = ERR_W'(diff_ff[PERR_W-1] ? diff_neg : diff_ff);
      integ_mag = integ_ff[IW-1] ? IW'(-integ_ff) : IW'(integ_ff);
      quo_cap   = (div_rsp.quo > TERM_MAX) ? TERM_MAX : div_rsp.quo;
      tot_shift = total_ff >> GAIN_FRAC_BITS;
      tot_pos   = !total_ff[SUM_W-1] && (total_ff != '0);
   end

   // operand selection for the shared serial units
   always_comb begin
      mul_req = '0;
      div_req = '0;
      unique case (state_ff)
         ST_MUL_P: begin
            mul_req.a = MUL_A_W'(cfg.gain_p);
            mul_req.b = {err_mag, {(MUL_B_W-ERR_W){1'b0}}};
            mul_req.steps = STEP_W'(ERR_W);
         end
         ST_MUL_D1: begin
            mul_req.a = MUL_A_W'(cfg.gain_d);
            mul_req.b = {diff_mag, {(MUL_B_W-ERR_W){1'b0}}};
            mul_req.steps = STEP_W'(ERR_W);
         end
         ST_MUL_D2: begin
            mul_req.a = MUL_A_W'(mul_rsp.prod);
            mul_req.b = {K_THOUSAND, {(MUL_B_W-K_W){1'b0}}};
            mul_req.steps = STEP_W'(K_W);
         end
         ST_MUL_I1: begin
            mul_req.a = MUL_A_W'(integ_mag);
            mul_req.b = cfg.gain_i;
            mul_req.steps = STEP_W'(MUL_B_W);
         end
         ST_MUL_I2: begin
            mul_req.a = MUL_A_W'(mul_rsp.prod);
            mul_req.b = {dt_ff, {(MUL_B_W-DT_W){1'b0}}};
            mul_req.steps = STEP_W'(DT_W);
         end
         ST_DIV_D: begin
            div_req.num = mul_rsp.prod;
            div_req.den = FFDIV_W'(dt_ff);
         end
         ST_DIV_I: begin
            div_req.num = mul_rsp.prod;
            div_req.den = FFDIV_W'(K_THOUSAND);
         end
         ST_DIV_F: begin
            div_req.num = PROD_W'(cfg.speed_target) << (FFDIV_FRAC + GAIN_FRAC_BITS);
            div_req.den = (cfg.ff_divisor == '0) ? FFDIV_W'(1) : cfg.ff_divisor;
         end
         default: begin
            mul_req = '0;
            div_req = '0;
         end
      endcase
      mul_req.start = go_ff && (state_ff == ST_MUL_P || state_ff == ST_MUL_D1 ||
                      state_ff == ST_MUL_D2 || state_ff == ST_MUL_I1 ||
                      state_ff == ST_MUL_I2);
      div_req.start = go_ff && (state_ff == ST_DIV_D || state_ff == ST_DIV_I ||
                      state_ff == ST_DIV_F);
   end

   // term to add into the running sum
   always_comb begin
      term_mag = '0;
      term_neg = 1'b0;
      term_add = 1'b0;
      unique case (state_ff)
         ST_MUL_P: begin
            term_mag = SUM_W'(mul_rsp.prod);
            term_neg = err_ff[ERR_W-1];
            term_add = mul_rsp.done;
         end
         ST_DIV_D: begin
            term_mag = SUM_W'(quo_cap);
            term_neg = diff_ff[PERR_W-1];
            term_add = div_rsp.done;
         end
         ST_DIV_I: begin
            term_mag = SUM_W'(quo_cap);
            term_neg = integ_ff[IW-1];
            term_add = div_rsp.done;
         end
         ST_DIV_F: begin
            term_mag = SUM_W'(div_rsp.quo);
            term_add = div_rsp.done;
         end
         ST_SUM: begin
            term_mag = SUM_W'(cfg.ff_fixed) << GAIN_FRAC_BITS;
            term_add = (cfg.ff_mode == FF_FIXED);
         end
         default: begin
            term_add = 1'b0;
         end
      endcase
      term_val = term_neg ? -signed'(term_mag) : signed'(term_mag);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      speed_in  = speed_ff;
      dt_in     = dt_ff;
      err_in    = err_ff;
      diff_in   = diff_ff;
      run_in    = run_ff;
      total_in  = term_add ? total_ff + term_val : total_ff;
      integ_in  = integ_ff;
      perr_in   = perr_ff;
      pspeed_in = pspeed_ff;
      held_in   = held_ff;
      rdrive_in = rdrive_ff;
      rrecomp_in = rrecomp_ff;
      rerr_in   = rerr_ff;
      rvalid_in = rsp_tready ? 1'b0 : rvalid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               speed_in = meas;
               dt_in    = (elapsed == '0) ? DT_W'(1) : elapsed;
               err_in   = err_now;
               run_in   = (meas != pspeed_ff);
               total_in = '0;
               if (meas != pspeed_ff) begin
                  // saturate the integral at its signed limits
                  if (integ_sum[IW] != integ_sum[IW-1]) begin
                     integ_in = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}}
                                              : {1'b0, {(IW-1){1'b1}}};
                  end else begin
                     integ_in = integ_sum[IW-1:0];
                  end
                  diff_in  = perr_ff - PERR_W'(err_now);
                  state_in = ST_MUL_P;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_MUL_P:  if (mul_rsp.done) state_in = ST_MUL_D1;
         ST_MUL_D1: if (mul_rsp.done) state_in = ST_MUL_D2;
         ST_MUL_D2: if (mul_rsp.done) state_in = ST_DIV_D;
         ST_DIV_D:  if (div_rsp.done) state_in = ST_MUL_I1;
         ST_MUL_I1: if (mul_rsp.done) state_in = ST_MUL_I2;
         ST_MUL_I2: if (mul_rsp.done) state_in = ST_DIV_I;
         ST_DIV_I: begin
            if (div_rsp.done) begin
               state_in = (cfg.ff_mode == FF_PROP) ? ST_DIV_F : ST_SUM;
            end
         end
         ST_DIV_F:  if (div_rsp.done) state_in = ST_SUM;
         ST_SUM:    state_in = ST_DUTY;
         ST_DUTY: begin
            // truncate to the integer duty and clamp to 0..255
            if (!tot_pos) begin
               held_in = '0;
            end else if (tot_shift > SUM_W'(255)) begin
               held_in = '1;
            end else begin
               held_in = tot_shift[DUTY_W-1:0];
            end
            perr_in   = PERR_W'(err_ff);
            pspeed_in = speed_ff;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rvalid_in  = 1'b1;
               rdrive_in  = cfg.motor_enable ? held_ff : '0;
               rrecomp_in = run_ff;
               rerr_in    = err_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      go_in = (state_in != state_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         go_ff     <= 1'b0;
         rvalid_ff <= 1'b0;
         integ_ff  <= '0;
         perr_ff   <= '0;
         pspeed_ff <= '0;
         held_ff   <= DUTY_RST;
      end else begin
         state_ff  <= state_in;
         go_ff     <= go_in;
         rvalid_ff <= rvalid_in;
         integ_ff  <= integ_in;
         perr_ff   <= perr_in;
         pspeed_ff <= pspeed_in;
         held_ff   <= held_in;
      end
      speed_ff   <= speed_in;
      dt_ff      <= dt_in;
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      run_ff     <= run_in;
      total_ff   <= total_in;
      rdrive_ff  <= rdrive_in;
      rrecomp_ff <= rrecomp_in;
      rerr_ff    <= rerr_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {7'b0, rerr_ff, rdrive_ff};
   assign rsp_tuser  = rrecomp_ff;

   // only one serial unit works at a time
   a_units_excl: assert property (@(posedge clock) disable iff (reset)
      !(mul_rsp.busy && div_rsp.busy))
      else $error("multiplier and divider busy together");

   // the multiplier is never restarted while it is still working
   a_mul_start_free: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_rsp.busy)
      else $error("multiplier restarted while busy");

   // the integral moves only when a transaction is taken
   a_integ_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(integ_ff))
      else $error("integral changed without a transaction");

   // a finished item waits while the output register is still occupied
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rvalid_ff && !rsp_tready) |=> (state_ff == ST_OUT))
      else $error("result overwrote a pending transaction");

   // drive is gated off while the motor is disabled
   a_drive_gated: assert property (@(posedge clock) disable iff (reset)
      (rvalid_in && !rvalid_ff && !cfg.motor_enable) |=> (rdrive_ff == '0))
      else $error("drive set while motor disabled");

endmodule

// ----- bench/pid_speed_loop_feedforward_unit_tb.sv -----
// ----------------------------------------------------------------------------
// pid_speed_loop_feedforward_unit_tb - self-checking bench for the speed loop
// Sends speed measurements on the req stream and programs gains, target,
// feedforward and enable over the csr port. Every rsp transaction is checked
// against an untimed model of the PID update with feedforward. Traffic runs
// with random idling on both sides and includes one long output stall.
// ----------------------------------------------------------------------------
module pid_speed_loop_feedforward_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pslf_pkg::*;

   localparam int FRAC  = GAIN_FRAC_BITS_DEF;
   localparam int INT_W = INTEGRAL_WIDTH_DEF;

   // saturation points of the model arithmetic; the term limit matches TERM_MAX
   localparam logic [63:0] PRODUCT_LIMIT = 64'd1 << 62;
   localparam logic [63:0] TERM_LIMIT    = 64'd1 << 50;

   // the fourth feedforward code has no name in the package and adds nothing
   localparam logic [MODE_W-1:0] FF_SPARE = 2'd3;

   localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(((64'd1 << FRAC) + 64'd10) / 64'd20);
   localparam logic [GAIN_W-1:0] GAIN_ID_RST =
      GAIN_W'(((64'd1 << FRAC) + 64'd5000) / 64'd10000);

   localparam int WATCHDOG_LIMIT = 20000;  // cycles with no transaction at all
   localparam int SETTLE_CYCLES  = 400;    // above the slowest update
   localparam int STALL_CYCLES   = 1500;   // long receiver hold-off

   typedef struct packed {
      logic [DUTY_W-1:0] drive;
      logic              recomputed;
      logic [ERR_W-1:0]  speed_error;
   } loop_result_type;

   // ------------------------------------------------------------------------
   // DUT connections
   // ------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata = '0;   // speed_meas[15:0], elapsed_us[31:16]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;        // drive[7:0], speed_error[24:8], zeros
   logic                  rsp_tuser;        // recomputed

   pid_speed_loop_feedforward_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Loop model: register copy and controller state
   // ------------------------------------------------------------------------
   cfg_type            shadow_cfg;
   longint             integral_acc;
   int                 last_error;
   logic [SPEED_W-1:0] last_speed;
   logic [DUTY_W-1:0]  held_duty;

   loop_result_type    expected_results[$];
   loop_result_type    oldest_expected;

   // traffic control and bookkeeping
   int unsigned        send_idle_pct = 0;
   int unsigned        recv_idle_pct = 0;
   int                 rsp_hold_left = 0;
   int                 quiet_cycles = 0;
   int                 mismatch_count = 0;
   int                 items_sent = 0;
   int                 updates_seen = 0;
   int                 csr_writes = 0;
   logic [SPEED_W-1:0] last_sent_speed = '0;

   function automatic void reset_speed_model();
      shadow_cfg.gain_p       = GAIN_P_RST;
      shadow_cfg.gain_i       = GAIN_ID_RST;
      shadow_cfg.gain_d       = GAIN_ID_RST;
      shadow_cfg.speed_target = TARGET_RST;
      shadow_cfg.ff_mode      = FF_PROP;
      shadow_cfg.ff_fixed     = DUTY_RST;
      shadow_cfg.ff_divisor   = FFDIV_RST;
      shadow_cfg.motor_enable = 1'b0;
      integral_acc = 0;
      last_error   = 0;
      last_speed   = '0;
      held_duty    = DUTY_RST;
   endfunction

   function automatic void apply_register(reg_idx_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_GAIN_P:     shadow_cfg.gain_p       = value;
         REG_GAIN_I:     shadow_cfg.gain_i       = value;
         REG_GAIN_D:     shadow_cfg.gain_d       = value;
         REG_TARGET:     shadow_cfg.speed_target = value[TARGET_W-1:0];
         REG_FF_MODE:    shadow_cfg.ff_mode      = value[MODE_W-1:0];
         REG_FF_FIXED:   shadow_cfg.ff_fixed     = value[DUTY_W-1:0];
         REG_FF_DIVISOR: shadow_cfg.ff_divisor   = value[FFDIV_W-1:0];
         REG_ENABLE:     shadow_cfg.motor_enable = value[0];
         default: ;
      endcase
   endfunction

   // product clipped at the inner saturation point
   function automatic logic [63:0] sat_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] full;
      full = 128'(a) * 128'(b);
      return (full > 128'(PRODUCT_LIMIT)) ? PRODUCT_LIMIT : full[63:0];
   endfunction

   function automatic logic [63:0] sat_term(logic [63:0] m);
      return (m > TERM_LIMIT) ? TERM_LIMIT : m;
   endfunction

   function automatic longint with_sign(logic [63:0] m, bit neg);
      longint v;
      v = longint'(m);
      return neg ? -v : v;
   endfunction

   // Advance the controller by one measurement and return the result it gives.
   // Each term works on magnitudes, truncates toward zero and then takes its sign.
   function automatic loop_result_type predict_speed_step(logic [SPEED_W-1:0] speed,
                                                          logic [DT_W-1:0] elapsed);
      loop_result_type res;
      int              err;
      int              diff;
      bit              run;
      logic [63:0]     dt;
      logic [63:0]     mag;
      logic [63:0]     m;
      logic [63:0]     divisor;
      longint          total;
      longint          imax;
      longint          imin;
      err = int'(shadow_cfg.speed_target) - int'(speed);
      run = (speed != last_speed);
      dt  = (elapsed == '0) ? 64'd1 : 64'(elapsed);
      if (run) begin
         // saturating integral at the signed accumulator limits
         imax = (longint'(1) <<< (INT_W - 1)) - 1;
         imin = -imax - 1;
         if (err > 0 && integral_acc > imax - err)
            integral_acc = imax;
         else if (err < 0 && integral_acc < imin - err)
            integral_acc = imin;
         else
            integral_acc += err;

         mag   = (err < 0) ? 64'(-err) : 64'(err);
         total = with_sign(sat_term(64'(shadow_cfg.gain_p) * mag), err < 0);

         diff  = last_error - err;
         mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
         m     = sat_product(64'(shadow_cfg.gain_d) * mag, 64'd1000) / dt;
         total += with_sign(sat_term(m), diff < 0);

         mag   = (integral_acc < 0) ? 64'(-integral_acc) : 64'(integral_acc);
         m     = sat_product(sat_product(64'(shadow_cfg.gain_i), mag), dt) / 64'd1000;
         total += with_sign(sat_term(m), integral_acc < 0);

         case (shadow_cfg.ff_mode)
            FF_FIXED: total += longint'(64'(shadow_cfg.ff_fixed) << FRAC);
            FF_PROP: begin
               // a zero divisor counts as the smallest step
               divisor = (shadow_cfg.ff_divisor == '0) ? 64'd1 : 64'(shadow_cfg.ff_divisor);
               total += longint'((64'(shadow_cfg.speed_target) << (FFDIV_FRAC + FRAC))
                                 / divisor);
            end
            default: ;
         endcase

         if (total <= 0)
            held_duty = '0;
         else if ((total >>> FRAC) > 255)
            held_duty = '1;
         else
            held_duty = DUTY_W'(total >>> FRAC);

         last_error = err;
         last_speed = speed;
      end
      res.drive       = shadow_cfg.motor_enable ? held_duty : '0;
      res.recomputed  = run;
      res.speed_error = ERR_W'(err);
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Receiver: random idling, or a counted hold-off when one is requested
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready    = 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Result checker: compare each rsp transaction with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("rsp transaction with no measurement outstanding: tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            oldest_expected = expected_results.pop_front();
            if (rsp_tdata[DUTY_W-1:0] !== oldest_expected.drive) begin
               $error("drive: expected %0d, got %0d",
                      oldest_expected.drive, rsp_tdata[DUTY_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tuser !== oldest_expected.recomputed) begin
               $error("recomputed: expected %0b, got %0b",
                      oldest_expected.recomputed, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[DUTY_W +: ERR_W] !== oldest_expected.speed_error) begin
               $error("speed_error: expected %0d, got %0d",
                      $signed(oldest_expected.speed_error),
                      $signed(rsp_tdata[DUTY_W +: ERR_W]));
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run when nothing moves for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_results.size());
         $display("pid_speed_loop_feedforward_unit_tb: errors");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   // ------------------------------------------------------------------------
   // Shared tasks
   // ------------------------------------------------------------------------
   // change idling odds on a rising edge, away from the falling-edge drivers
   task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Offer one measurement, hold it until taken, then predict its result.
   // Leave tvalid high on return so back-to-back transactions stay seamless.
   task automatic send_measurement(logic [SPEED_W-1:0] speed, logic [DT_W-1:0] elapsed);
      loop_result_type res;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {elapsed, speed};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      res = predict_speed_step(speed, elapsed);
      expected_results.push_back(res);
      last_sent_speed = speed;
      items_sent++;
      if (res.recomputed)
         updates_seen++;
   endtask

   // drop the request and wait for every outstanding result
   task automatic wait_until_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // setup cycle, then access cycle; the register loads at the access edge
   task automatic write_register(reg_idx_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_register(idx, value);
      csr_writes++;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Random value pickers, biased towards the extremes
   // ------------------------------------------------------------------------
   function automatic logic [SPEED_W-1:0] pick_speed();
      int roll;
      int s;
      roll = $urandom_range(99);
      // repeat the last speed so the held duty path is exercised
      if (roll < 25)
         return last_sent_speed;
      // hover round the target as a running loop would
      if (roll < 70) begin
         s = int'(shadow_cfg.speed_target) + int'($urandom_range(2000)) - 1000;
         return SPEED_W'((s < 0) ? 0 : s);
      end
      return SPEED_W'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic [DT_W-1:0] pick_elapsed();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return '0;
      if (roll < 20)
         return '1;
      if (roll < 40)
         return DT_W'($urandom);
      return DT_W'($urandom_range(20000, 500));
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain(logic [GAIN_W-1:0] typical_max);
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return '0;
      if (roll < 20)
         return '1;
      if (roll < 75)
         return GAIN_W'($urandom_range(typical_max));
      return GAIN_W'($urandom);
   endfunction

   task automatic randomize_settings();
      int roll;
      logic [CSR_DATA_W-1:0] target;
      logic [CSR_DATA_W-1:0] divisor;
      roll = $urandom_range(99);
      if (roll < 10)
         target = '0;
      else if (roll < 20)
         target = 32'h7FFF;
      else
         target = $urandom_range(32'h7FFF);
      roll = $urandom_range(99);
      if (roll < 5)
         divisor = '0;
      else if (roll < 10)
         divisor = 32'd1;
      else if (roll < 15)
         divisor = 32'hFF_FFFF;
      else if (roll < 75)
         divisor = $urandom_range(102400, 6400);
      else
         divisor = {8'h00, 24'($urandom)};
      write_register(REG_GAIN_P, pick_gain(32'h0100_0000));
      write_register(REG_GAIN_I, pick_gain(32'h0001_0000));
      write_register(REG_GAIN_D, pick_gain(32'h0001_0000));
      write_register(REG_TARGET, target);
      write_register(REG_FF_MODE, $urandom_range(3));
      write_register(REG_FF_FIXED, $urandom_range(255));
      write_register(REG_FF_DIVISOR, divisor);
      write_register(REG_ENABLE, ($urandom_range(99) < 85) ? 32'd1 : 32'd0);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset values: drive stays 0 until enabled, a first speed of 0 matches
   // the cleared previous speed, then the held duty shows once enabled.
   task automatic test_reset_defaults();
      send_measurement(16'd0, 16'd1000);
      send_measurement(16'd19200, 16'd1000);
      wait_until_idle();
      write_register(REG_ENABLE, 32'd1);
      send_measurement(16'd19200, 16'd1000);
      send_measurement(16'd18000, 16'd1000);
      wait_until_idle();
   endtask

   // Speed and elapsed time at their limits, zero elapsed time among them.
   task automatic test_field_extremes();
      send_measurement(16'hFFFF, 16'h0000);
      send_measurement(16'hFFFF, 16'hFFFF);
      send_measurement(16'h0000, 16'hFFFF);
      send_measurement(16'h0000, 16'h0000);
      send_measurement(16'h0001, 16'h0000);
      send_measurement(16'h7FFF, 16'h0001);
      wait_until_idle();
   endtask

   // Every feedforward code, the fixed value at both ends and the divisor
   // at zero, one and all ones.
   task automatic test_feedforward_modes();
      logic [MODE_W-1:0] modes[4];
      modes = '{FF_NONE, FF_FIXED, FF_PROP, FF_SPARE};
      write_register(REG_FF_FIXED, 32'd255);
      write_register(REG_FF_DIVISOR, 32'd0);
      for (int i = 0; i < 4; i++) begin
         wait_until_idle();
         write_register(REG_FF_MODE, 32'(modes[i]));
         send_measurement(SPEED_W'(18000 + 300 * i), 16'd2000);
         send_measurement(SPEED_W'(20000 - 300 * i), 16'd2000);
      end
      wait_until_idle();
      write_register(REG_FF_FIXED, 32'd0);
      write_register(REG_FF_DIVISOR, 32'hFF_FFFF);
      write_register(REG_FF_MODE, 32'(FF_FIXED));
      send_measurement(16'd17000, 16'd500);
      wait_until_idle();
      write_register(REG_FF_MODE, 32'(FF_PROP));
      send_measurement(16'd17100, 16'd500);
      wait_until_idle();
      write_register(REG_FF_DIVISOR, 32'd1);
      send_measurement(16'd17200, 16'd500);
      wait_until_idle();
   endtask

   // All gains at full scale with the target at its top, then all at zero.
   task automatic test_gain_extremes();
      write_register(REG_GAIN_P, '1);
      write_register(REG_GAIN_I, '1);
      write_register(REG_GAIN_D, '1);
      write_register(REG_TARGET, 32'h7FFF);
      send_measurement(16'h0000, 16'h0001);
      send_measurement(16'hFFFF, 16'hFFFF);
      wait_until_idle();
      write_register(REG_GAIN_P, '0);
      write_register(REG_GAIN_I, '0);
      write_register(REG_GAIN_D, '0);
      write_register(REG_TARGET, 32'd0);
      send_measurement(16'd100, 16'd10);
      send_measurement(16'd0, 16'd10);
      wait_until_idle();
   endtask

   // Random measurements under a run of random register settings.
   task automatic test_random_traffic(int settings, int per_setting);
      for (int s = 0; s < settings; s++) begin
         wait_until_idle();
         randomize_settings();
         for (int n = 0; n < per_setting; n++)
            send_measurement(pick_speed(), pick_elapsed());
      end
      wait_until_idle();
   endtask

   // Hold the receiver off while measurements keep coming, so the output
   // register fills and the block has to stall its input.
   task automatic test_output_stall();
      wait_until_idle();
      write_register(REG_ENABLE, 32'd1);
      @(posedge clock);
      rsp_hold_left = STALL_CYCLES;
      for (int n = 0; n < 12; n++)
         send_measurement(SPEED_W'(1000 + 37 * n), DT_W'(1000 + n));
      wait_until_idle();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset_speed_model();
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_feedforward_modes();
      test_gain_extremes();

      // slow sender and a mostly stalled receiver, then the reverse, then none
      set_idling(36, 81);
      test_random_traffic(4, 140);
      set_idling(81, 36);
      test_random_traffic(4, 140);
      set_idling(0, 0);
      test_random_traffic(4, 140);

      test_output_stall();

      // allow for a stray result after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d measurements: %0d ran the PID update, %0d kept the held duty",
               items_sent, updates_seen, items_sent - updates_seen);
      $display("over %0d register writes, with random idling and one long output stall",
               csr_writes);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("pid_speed_loop_feedforward_unit_tb: clean");
      end else begin
         $display("pid_speed_loop_feedforward_unit_tb: errors");
      end
      $finish;
   end

endmodule
